@@ design/prs_pkg.sv @@
// Shared constants and types for the poll request scheduler.
package prs_pkg;

  localparam int MAX_ENTRIES_DEF = 16;

  localparam logic [1:0] ST_INIT      = 2'd0;
  localparam logic [1:0] ST_UPDATE    = 2'd1;
  localparam logic [1:0] ST_REQUESTED = 2'd2;
  localparam logic [1:0] ST_ERROR     = 2'd3;

  localparam logic [1:0] OP_POLL         = 2'd0;
  localparam logic [1:0] OP_SEQ_UPDATE   = 2'd1;
  localparam logic [1:0] OP_RESPONSE     = 2'd2;
  localparam logic [1:0] OP_ERROR_REPORT = 2'd3;

  localparam logic [1:0] REG_ACTIVE_ENTRIES   = 2'd0;
  localparam logic [1:0] REG_RETRY_TIMEOUT    = 2'd1;
  localparam logic [1:0] REG_RESPONSE_TIMEOUT = 2'd2;

  localparam logic [4:0]  ACTIVE_ENTRIES_RST   = 5'd15;
  localparam logic [15:0] RETRY_TIMEOUT_RST    = 16'd500;
  localparam logic [15:0] RESPONSE_TIMEOUT_RST = 16'd2000;

  typedef struct packed {
    logic [1:0]  state;
    logic [31:0] last_seq;
    logic [31:0] req_time;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

@@ design/prs_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module prs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ design/poll_request_scheduler_core.sv @@
// Poll request scheduler: entry table in RAM, scan sequencer and config registers.
//
// Usage:
//   Input: drive in_* and raise start; a transaction is taken at an edge with busy low.
//   Output: each input transaction yields one result on out_* for one cycle, marked by
//   out_strobe. The receiver cannot stall, so results must be captured when shown.
//   Config: cfg_valid/cfg_ready write port (cfg_ready is always high), cfg_index
//   selects active_entries, retry_timeout_ms or response_timeout_ms.
// Timing:
//   Response reports, polls with the link down and reports for inactive entries:
//   result in the cycle after acceptance, busy stays low.
//   Sequence updates and error reports: busy for one cycle, result shown as busy falls.
//   Polls: busy while entries are read and evaluated in turn from the scan start,
//   until one is taken or the last active entry has been scanned; result shown
//   in the same cycle that busy falls. The table RAM delivers one entry
//   per cycle, which sets the scan rate.
// Reset:
//   rst_n clears the table through per-entry valid bits, so the block takes a
//   transaction in the first cycle after reset; config registers take defaults.
module poll_request_scheduler_core #(
  parameter int MAX_ENTRIES = prs_pkg::MAX_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_operation,
  input  logic [31:0]        in_now_ms,
  input  logic               in_link_up,
  input  logic [3:0]         in_entry_index,
  input  logic signed [31:0] in_seq_value,
  output logic               out_strobe,
  output logic               out_request_valid,
  output logic [3:0]         out_request_entry,
  output logic               out_reconnect,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam int IW = $clog2(MAX_ENTRIES);
  localparam int NW = $clog2(MAX_ENTRIES + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_RMW  = 2'd2;

  logic [1:0]             state_r, state_nxt;
  logic [MAX_ENTRIES-1:0] valid_r, valid_nxt;
  logic [IW-1:0]          cursor_r, cursor_nxt;
  logic                   cursor_vld_r, cursor_vld_nxt;
  logic [31:0]            lrt_r, lrt_nxt;
  logic [4:0]             active_r, active_nxt;
  logic [15:0]            retry_r, retry_nxt;
  logic [15:0]            resp_r, resp_nxt;
  logic                   ev_vld_r, ev_vld_nxt;
  logic [IW-1:0]          ev_i_r, ev_i_nxt;
  logic [NW-1:0]          rd_i_r, rd_i_nxt;
  logic                   valid_q_r, valid_q_nxt;
  logic [31:0]            now_r, now_nxt;
  logic [31:0]            seq_r, seq_nxt;
  logic [1:0]             op_r, op_nxt;
  logic                   recon_r, recon_nxt;
  logic                   out_strobe_r, out_strobe_nxt;
  logic                   out_rv_r, out_rv_nxt;
  logic [3:0]             out_re_r, out_re_nxt;
  logic                   out_rc_r, out_rc_nxt;

  logic                    mem_we;
  logic [IW-1:0]           mem_waddr;
  logic [IW-1:0]           mem_raddr;
  logic [prs_pkg::ENTRY_W-1:0] mem_rdata;
  prs_pkg::entry_t         rd_word;
  prs_pkg::entry_t         wr_word;

  logic [7:0]    n8;
  logic [NW-1:0] n;
  logic          in_accept;
  logic          idx_ok;
  logic [IW-1:0] idx_addr;
  logic          expired;
  logic [31:0]   kick_val;
  logic [NW-1:0] cur_n;
  logic [NW-1:0] start_idx;
  logic [1:0]    cur_state;
  logic [31:0]   cur_seq;
  logic          take;

  prs_ram #(
    .WIDTH(prs_pkg::ENTRY_W),
    .DEPTH(MAX_ENTRIES)
  ) u_table (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(wr_word),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  assign rd_word   = prs_pkg::entry_t'(mem_rdata);
  assign cur_state = valid_q_r ? rd_word.state : prs_pkg::ST_INIT;
  assign cur_seq   = valid_q_r ? rd_word.last_seq : 32'd0;

  assign n8 = (active_r == 5'd0) ? 8'd1 :
              ((8'(active_r) > 8'(MAX_ENTRIES)) ? 8'(MAX_ENTRIES) : 8'(active_r));
  assign n  = NW'(n8);

  assign in_accept = start && !busy;
  assign idx_ok    = 8'(in_entry_index) < n8;
  assign idx_addr  = IW'(in_entry_index);
  assign expired   = {1'b0, in_now_ms} > ({1'b0, lrt_r} + {17'd0, resp_r});
  assign kick_val  = (in_now_ms > lrt_r) ? in_now_ms : lrt_r;
  assign cur_n     = NW'(cursor_r);
  assign start_idx = (expired || !cursor_vld_r || cur_n >= n || cur_n == n - NW'(1)) ?
                     '0 : cur_n;

  assign take = (cur_state == prs_pkg::ST_INIT) || (cur_state == prs_pkg::ST_UPDATE) ||
                ((cur_state == prs_pkg::ST_REQUESTED) &&
                 (({1'b0, rd_word.req_time} + {17'd0, retry_r}) < {1'b0, now_r}));

  always_comb begin
    state_nxt      = state_r;
    valid_nxt      = valid_r;
    cursor_nxt     = cursor_r;
    cursor_vld_nxt = cursor_vld_r;
    lrt_nxt        = lrt_r;
    ev_vld_nxt     = 1'b0;
    ev_i_nxt       = ev_i_r;
    rd_i_nxt       = rd_i_r;
    now_nxt        = now_r;
    seq_nxt        = seq_r;
    op_nxt         = op_r;
    recon_nxt      = recon_r;
    out_strobe_nxt = 1'b0;
    out_rv_nxt     = out_rv_r;
    out_re_nxt     = out_re_r;
    out_rc_nxt     = out_rc_r;
    mem_we         = 1'b0;
    mem_waddr      = ev_i_r;
    mem_raddr      = rd_i_r[IW-1:0];
    wr_word.state    = cur_state;
    wr_word.last_seq = cur_seq;
    wr_word.req_time = rd_word.req_time;

    unique case (state_r)
      S_IDLE: begin
        mem_raddr = idx_addr;
        if (in_accept) begin
          now_nxt  = in_now_ms;
          seq_nxt  = $unsigned(in_seq_value);
          op_nxt   = in_operation;
          ev_i_nxt = idx_addr;
          unique case (in_operation)
            prs_pkg::OP_POLL: begin
              if (!in_link_up) begin
                lrt_nxt        = kick_val;
                valid_nxt      = '0;
                cursor_nxt     = '0;
                cursor_vld_nxt = 1'b0;
                out_strobe_nxt = 1'b1;
                out_rv_nxt     = 1'b0;
                out_re_nxt     = 4'd0;
                out_rc_nxt     = 1'b1;
              end else begin
                recon_nxt = expired;
                if (expired) begin
                  lrt_nxt        = kick_val;
                  valid_nxt      = '0;
                  cursor_nxt     = '0;
                  cursor_vld_nxt = 1'b0;
                end
                rd_i_nxt  = start_idx;
                state_nxt = S_SCAN;
              end
            end
            prs_pkg::OP_SEQ_UPDATE, prs_pkg::OP_ERROR_REPORT: begin
              if (idx_ok) begin
                state_nxt = S_RMW;
              end else begin
                out_strobe_nxt = 1'b1;
                out_rv_nxt     = 1'b0;
                out_re_nxt     = 4'd0;
                out_rc_nxt     = 1'b0;
              end
            end
            prs_pkg::OP_RESPONSE: begin
              lrt_nxt        = kick_val;
              out_strobe_nxt = 1'b1;
              out_rv_nxt     = 1'b0;
              out_re_nxt     = 4'd0;
              out_rc_nxt     = 1'b0;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (rd_i_r < n) begin
          ev_vld_nxt = 1'b1;
          ev_i_nxt   = rd_i_r[IW-1:0];
          rd_i_nxt   = rd_i_r + NW'(1);
        end
        if (ev_vld_r) begin
          if (cur_state == prs_pkg::ST_ERROR) begin
            mem_we        = 1'b1;
            wr_word.state = prs_pkg::ST_INIT;
          end else if (take) begin
            mem_we           = 1'b1;
            wr_word.state    = prs_pkg::ST_REQUESTED;
            wr_word.req_time = now_r;
            cursor_nxt       = ev_i_r;
            cursor_vld_nxt   = 1'b1;
            ev_vld_nxt       = 1'b0;
            out_strobe_nxt   = 1'b1;
            out_rv_nxt       = 1'b1;
            out_re_nxt       = 4'(ev_i_r);
            out_rc_nxt       = recon_r;
            state_nxt        = S_IDLE;
          end
        end else if (rd_i_r >= n) begin
          cursor_nxt     = '0;
          cursor_vld_nxt = 1'b0;
          out_strobe_nxt = 1'b1;
          out_rv_nxt     = 1'b0;
          out_re_nxt     = 4'd0;
          out_rc_nxt     = recon_r;
          state_nxt      = S_IDLE;
        end
      end
      S_RMW: begin
        if (op_r == prs_pkg::OP_SEQ_UPDATE) begin
          if (cur_seq != seq_r) begin
            mem_we           = 1'b1;
            wr_word.state    = prs_pkg::ST_UPDATE;
            wr_word.last_seq = seq_r;
          end
        end else begin
          mem_we        = 1'b1;
          wr_word.state = prs_pkg::ST_ERROR;
        end
        out_strobe_nxt = 1'b1;
        out_rv_nxt     = 1'b0;
        out_re_nxt     = 4'd0;
        out_rc_nxt     = 1'b0;
        state_nxt      = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (mem_we) begin
      valid_nxt[mem_waddr] = 1'b1;
    end
    valid_q_nxt = valid_r[mem_raddr];
  end

  always_comb begin
    active_nxt = active_r;
    retry_nxt  = retry_r;
    resp_nxt   = resp_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        prs_pkg::REG_ACTIVE_ENTRIES:   active_nxt = cfg_data[4:0];
        prs_pkg::REG_RETRY_TIMEOUT:    retry_nxt  = cfg_data;
        prs_pkg::REG_RESPONSE_TIMEOUT: resp_nxt   = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      valid_r      <= '0;
      cursor_r     <= '0;
      cursor_vld_r <= 1'b0;
      lrt_r        <= 32'd0;
      active_r     <= prs_pkg::ACTIVE_ENTRIES_RST;
      retry_r      <= prs_pkg::RETRY_TIMEOUT_RST;
      resp_r       <= prs_pkg::RESPONSE_TIMEOUT_RST;
      ev_vld_r     <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      valid_r      <= valid_nxt;
      cursor_r     <= cursor_nxt;
      cursor_vld_r <= cursor_vld_nxt;
      lrt_r        <= lrt_nxt;
      active_r     <= active_nxt;
      retry_r      <= retry_nxt;
      resp_r       <= resp_nxt;
      ev_vld_r     <= ev_vld_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ev_i_r    <= ev_i_nxt;
    rd_i_r    <= rd_i_nxt;
    valid_q_r <= valid_q_nxt;
    now_r     <= now_nxt;
    seq_r     <= seq_nxt;
    op_r      <= op_nxt;
    recon_r   <= recon_nxt;
    out_rv_r  <= out_rv_nxt;
    out_re_r  <= out_re_nxt;
    out_rc_r  <= out_rc_nxt;
  end

  assign busy              = (state_r != S_IDLE);
  assign cfg_ready         = 1'b1;
  assign out_strobe        = out_strobe_r;
  assign out_request_valid = out_rv_r;
  assign out_request_entry = out_re_r;
  assign out_reconnect     = out_rc_r;

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result shown while a transaction is still in progress");

  a_every_item: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_strobe))
    else $error("accepted transaction neither in progress nor answered");

  a_link_down: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_operation == prs_pkg::OP_POLL && !in_link_up)
      |=> (out_strobe && out_reconnect && !out_request_valid))
    else $error("link loss poll did not report reconnect");

  a_cursor_match: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_request_valid) |-> (cursor_vld_r && 4'(cursor_r) == out_request_entry))
    else $error("issued entry differs from cursor");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && ev_vld_r) |-> (NW'(ev_i_r) < n))
    else $error("scan evaluated an inactive entry");

endmodule

@@ tb/sv/prs_checker.sv @@
`timescale 1ns / 100ps
// Checker for the poll request scheduler: mirrors the entry table and checks each result.
module prs_checker #(
  parameter int MAX_ENTRIES = prs_pkg::MAX_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic [1:0]         in_operation,
  input  logic [31:0]        in_now_ms,
  input  logic               in_link_up,
  input  logic [3:0]         in_entry_index,
  input  logic signed [31:0] in_seq_value,
  input  logic               out_strobe,
  input  logic               out_request_valid,
  input  logic [3:0]         out_request_entry,
  input  logic               out_reconnect,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output int                 fail_count,
  output int                 pending
);

  typedef struct packed {
    logic       request_valid;
    logic [3:0] request_entry;
    logic       reconnect;
  } poll_result_t;

  logic [1:0]   ent_state    [MAX_ENTRIES];
  logic [31:0]  ent_last_seq [MAX_ENTRIES];
  logic [31:0]  ent_req_time [MAX_ENTRIES];
  int           scan_cursor;
  bit           scan_cursor_ok;
  logic [31:0]  last_rsp_ms;
  logic [4:0]   active_reg;
  logic [15:0]  retry_reg;
  logic [15:0]  rsp_timeout_reg;
  poll_result_t due_results[$];

  function automatic void clear_table();
    int i;
    for (i = 0; i < MAX_ENTRIES; i++) begin
      ent_state[i] = prs_pkg::ST_INIT;
      ent_last_seq[i] = '0;
    end
    scan_cursor = 0;
    scan_cursor_ok = 1'b0;
  endfunction

  function automatic void kick_watchdog(logic [31:0] now);
    if (now > last_rsp_ms) last_rsp_ms = now;
  endfunction

  function automatic poll_result_t schedule_item(logic [1:0] op, logic [31:0] now,
                                                 logic link, logic [3:0] idx,
                                                 logic [31:0] seqv);
    poll_result_t res;
    int n, i, first, hit;
    res = '0;
    n = (active_reg == 0) ? 1 : ((active_reg > MAX_ENTRIES) ? MAX_ENTRIES : int'(active_reg));
    case (op)
      prs_pkg::OP_POLL: begin
        if (!link) begin
          kick_watchdog(now);
          clear_table();
          res.reconnect = 1'b1;
        end else begin
          if ({1'b0, now} > {1'b0, last_rsp_ms} + 33'(rsp_timeout_reg)) begin
            kick_watchdog(now);
            clear_table();
            res.reconnect = 1'b1;
          end
          first = (!scan_cursor_ok || scan_cursor >= n - 1) ? 0 : scan_cursor;
          hit = -1;
          for (i = first; i < n && hit < 0; i++) begin
            if (ent_state[i] == prs_pkg::ST_ERROR) ent_state[i] = prs_pkg::ST_INIT;
            else if (ent_state[i] != prs_pkg::ST_REQUESTED ||
                     {1'b0, ent_req_time[i]} + 33'(retry_reg) < {1'b0, now}) hit = i;
          end
          if (hit >= 0) begin
            ent_state[hit] = prs_pkg::ST_REQUESTED;
            ent_req_time[hit] = now;
            scan_cursor = hit;
            scan_cursor_ok = 1'b1;
            res.request_valid = 1'b1;
            res.request_entry = 4'(hit);
          end else begin
            scan_cursor = 0;
            scan_cursor_ok = 1'b0;
          end
        end
      end
      prs_pkg::OP_SEQ_UPDATE: begin
        if (idx < n && ent_last_seq[idx] != seqv) begin
          ent_last_seq[idx] = seqv;
          ent_state[idx] = prs_pkg::ST_UPDATE;
        end
      end
      prs_pkg::OP_RESPONSE: kick_watchdog(now);
      prs_pkg::OP_ERROR_REPORT: begin
        if (idx < n) ent_state[idx] = prs_pkg::ST_ERROR;
      end
    endcase
    return res;
  endfunction

  task automatic check_field(input string name, input logic [3:0] want, input logic [3:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : observe
    int i;
    poll_result_t want;
    if (!rst_n) begin
      clear_table();
      for (i = 0; i < MAX_ENTRIES; i++) ent_req_time[i] = '0;
      last_rsp_ms = '0;
      active_reg = prs_pkg::ACTIVE_ENTRIES_RST;
      retry_reg = prs_pkg::RETRY_TIMEOUT_RST;
      rsp_timeout_reg = prs_pkg::RESPONSE_TIMEOUT_RST;
      due_results.delete();
      fail_count = 0;
    end else begin
      if (out_strobe) begin
        if (due_results.size() == 0) begin
          $display("%0t: unexpected result: expected none, got valid %0d entry %0d reconnect %0d",
                   $time, out_request_valid, out_request_entry, out_reconnect);
          fail_count++;
        end else begin
          want = due_results.pop_front();
          check_field("request_valid", want.request_valid, out_request_valid);
          check_field("request_entry", want.request_entry, out_request_entry);
          check_field("reconnect", want.reconnect, out_reconnect);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          prs_pkg::REG_ACTIVE_ENTRIES:   active_reg = cfg_data[4:0];
          prs_pkg::REG_RETRY_TIMEOUT:    retry_reg = cfg_data;
          prs_pkg::REG_RESPONSE_TIMEOUT: rsp_timeout_reg = cfg_data;
          default: ;
        endcase
      end
      if (start && !busy)
        due_results.push_back(schedule_item(in_operation, in_now_ms, in_link_up,
                                            in_entry_index, in_seq_value));
    end
    pending <= due_results.size();
  end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// Testbench top for the poll request scheduler: clock, reset, stimulus and verdict.
module tb;

  localparam int IDLE_LIMIT  = 2000;
  localparam int PHASE_ITEMS = 80;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [1:0]         in_operation;
  logic [31:0]        in_now_ms;
  logic               in_link_up;
  logic [3:0]         in_entry_index;
  logic signed [31:0] in_seq_value;
  logic               out_strobe;
  logic               out_request_valid;
  logic [3:0]         out_request_entry;
  logic               out_reconnect;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [1:0]         cfg_index;
  logic [15:0]        cfg_data;
  int                 fail_count;
  int                 pending;
  int                 idle_cycles;
  logic [31:0]        clock_ms;
  bit                 back_to_back;

  poll_request_scheduler_core dut (.*);

  prs_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic drive_item(input logic [1:0] op, input logic [31:0] now, input logic link,
                            input logic [3:0] idx, input logic [31:0] seqv);
    int gap, r;
    r = $urandom_range(0, 99);
    if (back_to_back || r < 60) gap = 0;
    else if (r < 92) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 40);
    if (gap > 0) begin
      @(negedge clk);
      start = 1'b0;
      in_operation = 2'($urandom);
      in_now_ms = $urandom;
      in_link_up = 1'($urandom);
      in_entry_index = 4'($urandom);
      in_seq_value = $urandom;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_operation = op;
    in_now_ms = now;
    in_link_up = link;
    in_entry_index = idx;
    in_seq_value = seqv;
    start = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] index, input logic [15:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = index;
    cfg_data = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_regs(input logic [4:0] active, input logic [15:0] retry,
                          input logic [15:0] rsp_timeout);
    logic [10:0] junk;
    junk = 11'($urandom);
    write_reg(prs_pkg::REG_ACTIVE_ENTRIES, {junk, active});
    write_reg(prs_pkg::REG_RETRY_TIMEOUT, retry);
    write_reg(prs_pkg::REG_RESPONSE_TIMEOUT, rsp_timeout);
  endtask

  task automatic random_item();
    logic [1:0]  op;
    logic [31:0] now;
    logic [31:0] seqv;
    logic        link;
    int          r;
    r = $urandom_range(0, 99);
    op = (r < 50) ? prs_pkg::OP_POLL : (r < 70) ? prs_pkg::OP_SEQ_UPDATE :
         (r < 85) ? prs_pkg::OP_RESPONSE : prs_pkg::OP_ERROR_REPORT;
    r = $urandom_range(0, 99);
    if (r < 80) clock_ms += $urandom_range(0, 200);
    else if (r < 95) clock_ms += $urandom_range(200, 3000);
    else clock_ms += $urandom_range(3000, 70000);
    now = clock_ms;
    if (op == prs_pkg::OP_SEQ_UPDATE || op == prs_pkg::OP_ERROR_REPORT) now = $urandom;
    else if (op == prs_pkg::OP_RESPONSE && $urandom_range(0, 3) == 0)
      now = (clock_ms > 1000) ? clock_ms - $urandom_range(0, 1000) : '0;
    link = (op == prs_pkg::OP_POLL) ? ($urandom_range(0, 19) != 0) :
           1'($urandom_range(0, 1));
    seqv = $urandom_range(0, 1) ? 32'($urandom_range(0, 3)) : $urandom;
    drive_item(op, now, link, 4'($urandom_range(0, 15)), seqv);
  endtask

  initial begin
    int k;
    rst_n = 1'b0;
    start = 1'b0;
    in_operation = prs_pkg::OP_POLL;
    in_now_ms = '0;
    in_link_up = 1'b0;
    in_entry_index = '0;
    in_seq_value = '0;
    cfg_valid = 1'b0;
    cfg_index = prs_pkg::REG_ACTIVE_ENTRIES;
    cfg_data = '0;
    clock_ms = '0;
    back_to_back = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    drive_item(prs_pkg::OP_POLL, 32'd0, 1'b1, 4'd0, 32'd0);
    drive_item(prs_pkg::OP_POLL, 32'd0, 1'b1, 4'd15, 32'd0);
    drive_item(prs_pkg::OP_SEQ_UPDATE, 32'hFFFF_FFFF, 1'b0, 4'd0, 32'd0);
    drive_item(prs_pkg::OP_SEQ_UPDATE, 32'd0, 1'b1, 4'd0, 32'h7FFF_FFFF);
    drive_item(prs_pkg::OP_SEQ_UPDATE, 32'd5, 1'b0, 4'd1, 32'h8000_0000);
    drive_item(prs_pkg::OP_SEQ_UPDATE, 32'd5, 1'b1, 4'd15, 32'd5);
    drive_item(prs_pkg::OP_ERROR_REPORT, 32'hFFFF_FFFF, 1'b1, 4'd2, 32'hFFFF_FFFF);
    drive_item(prs_pkg::OP_ERROR_REPORT, 32'd7, 1'b0, 4'd15, 32'd0);
    drive_item(prs_pkg::OP_RESPONSE, 32'd100, 1'b1, 4'd0, 32'd0);
    drive_item(prs_pkg::OP_RESPONSE, 32'd50, 1'b0, 4'd0, 32'd0);
    drive_item(prs_pkg::OP_POLL, 32'd200, 1'b1, 4'd0, 32'd0);
    drive_item(prs_pkg::OP_POLL, 32'd300, 1'b1, 4'd0, 32'd0);
    drive_item(prs_pkg::OP_POLL, 32'd900, 1'b1, 4'd0, 32'd0);
    drive_item(prs_pkg::OP_POLL, 32'd2101, 1'b1, 4'd0, 32'd0);
    drive_item(prs_pkg::OP_POLL, 32'd2200, 1'b0, 4'd0, 32'd0);
    drive_item(prs_pkg::OP_ERROR_REPORT, 32'd2200, 1'b1, 4'd0, 32'd0);
    drive_item(prs_pkg::OP_SEQ_UPDATE, 32'd2200, 1'b1, 4'd14, 32'hFFFF_FFFF);
    drive_item(prs_pkg::OP_POLL, 32'd2300, 1'b1, 4'd0, 32'd0);
    drive_item(prs_pkg::OP_POLL, 32'd2400, 1'b1, 4'd0, 32'd0);
    drain();
    clock_ms = 32'd2400;

    for (k = 0; k < 6; k++) begin
      case (k)
        0: set_regs(5'd16, 16'd0, 16'hFFFF);
        1: set_regs(5'd1, 16'hFFFF, 16'd0);
        2: set_regs(5'd0, 16'd300, 16'd1500);
        3: set_regs(5'd31, 16'($urandom), 16'($urandom));
        4: set_regs(5'($urandom_range(2, 15)), 16'($urandom_range(0, 1000)),
                    16'($urandom_range(500, 4000)));
        default: set_regs(5'($urandom_range(1, 16)), 16'($urandom_range(100, 800)),
                          16'($urandom_range(1000, 5000)));
      endcase
      back_to_back = (k == 5);
      repeat (PHASE_ITEMS) random_item();
      drain();
    end

    // run the clock up to the top of the time range
    back_to_back = 1'b0;
    set_regs(5'd16, 16'hFFFF, 16'hFFFF);
    clock_ms = 32'hFFFF_0000;
    for (k = 1; k <= 20; k++)
      drive_item(prs_pkg::OP_POLL, clock_ms + k, 1'b1, 4'($urandom_range(0, 15)), $urandom);
    drive_item(prs_pkg::OP_POLL, 32'hFFFF_FFFF, 1'b1, 4'd0, 32'd0);
    drive_item(prs_pkg::OP_RESPONSE, 32'hFFFF_FFFF, 1'b1, 4'd0, 32'd0);
    drive_item(prs_pkg::OP_POLL, 32'hFFFF_FFFF, 1'b1, 4'd0, 32'd0);
    drain();
    repeat (20) @(negedge clk);

    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
